// ===== hdl/hcb_pkg.sv =====
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared constants and types of the Huffman code builder.
// ----------------------------------------------------------------------------
`default_nettype none

package hcb_pkg;

  // Default configuration of the block.
  localparam int ALPHABET_DEF   = 27;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed widths of the word fields.
  localparam int SYM_W   = 5;
  localparam int CODE_W  = 26;
  localparam int LEN_W   = 5;
  localparam int TOTAL_W = 32;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_COUNT  = 2'd1,
    CMD_BUILD  = 2'd2,
    CMD_ENCODE = 2'd3
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/hcb_if.sv =====
// ----------------------------------------------------------------------------
// hcb_if
// Valid/ready channels of the Huffman code builder: command in, table out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcb_item_if
  import hcb_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [1:0]       command;
  logic [SYM_W-1:0] symbol;

  modport source (output valid, command, symbol, input ready);
  modport sink   (input valid, command, symbol, output ready);
endinterface

interface hcb_result_if
  import hcb_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic [SYM_W-1:0]   out_symbol;
  logic [CODE_W-1:0]  code_word;
  logic [LEN_W-1:0]   code_length;
  logic [TOTAL_W-1:0] bit_total;
  logic               last;

  modport source (output valid, out_symbol, code_word, code_length, bit_total, last,
                  input ready);
  modport sink   (input valid, out_symbol, code_word, code_length, bit_total, last,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/hcb_ram.sv =====
// ----------------------------------------------------------------------------
// hcb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/huffman_code_builder.sv =====
// ----------------------------------------------------------------------------
// huffman_code_builder
// Counts symbols, builds a Huffman code table with a binary min-heap and
// answers encode requests from that table.
// ----------------------------------------------------------------------------
//
//  channel  role    words
//  -------  ------  ----------------------------------------------------------
//  item     sink    command, symbol
//  result   source  out_symbol, code_word, code_length, bit_total, last
//
//  Clear is done in IDLE and a count of a symbol in range passes through CNT;
//  encode waits in ENC on the output register. A build loads every used leaf
//  into the heap, sifts each entry down level by level (one heap memory read
//  port does all compares) and then places it, and walks every symbol's code
//  up the tree one level at a time. Reset is synchronous and clears control
//  state, the bit total and valid bits.
//  A stalled result port holds the sequencer in its output state.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_builder
  import hcb_pkg::*;
#(
  parameter int ALPHABET   = ALPHABET_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input wire logic     clk,
  input wire logic     rst,
  hcb_item_if.sink     item,
  hcb_result_if.source result
);

  // Widths derived from the alphabet size.
  localparam int LB  = $clog2(ALPHABET);        // leaf index
  localparam int NB  = $clog2(2 * ALPHABET);    // tree node index
  localparam int SB  = $clog2(ALPHABET + 1);    // heap size
  localparam int KB  = SB + 1;                  // heap position, holds 2*size
  localparam int HAW = $clog2(ALPHABET + 2);    // heap memory address
  localparam int WW  = COUNT_BITS + $clog2(ALPHABET);  // node weight
  localparam int HEW = NB + WW;                 // heap entry: node and weight
  localparam int PW  = NB + 1;                  // parent link and right flag
  localparam int CTW = LEN_W + CODE_W;          // code table entry

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [25:0] {
    IDLE    = 26'b1 << 0,
    CNT     = 26'b1 << 1,
    ENC     = 26'b1 << 2,
    L_RD    = 26'b1 << 3,
    L_WR    = 26'b1 << 4,
    H_START = 26'b1 << 5,
    H_RD    = 26'b1 << 6,
    H_GET   = 26'b1 << 7,
    H_NEXT  = 26'b1 << 8,
    S_CHK   = 26'b1 << 9,
    S_RJ    = 26'b1 << 10,
    S_RJ1   = 26'b1 << 11,
    S_CMP   = 26'b1 << 12,
    S_END   = 26'b1 << 13,
    M_TOP   = 26'b1 << 14,
    M_T     = 26'b1 << 15,
    M_L     = 26'b1 << 16,
    M_O     = 26'b1 << 17,
    M_O2    = 26'b1 << 18,
    M_P2    = 26'b1 << 19,
    F_RD    = 26'b1 << 20,
    F_WR    = 26'b1 << 21,
    D_RD    = 26'b1 << 22,
    D_W     = 26'b1 << 23,
    D_P     = 26'b1 << 24,
    D_OUT   = 26'b1 << 25
  } state_t;

  state_t state, ret;

  // Sequencer registers.
  logic [SB-1:0]      size;      // live heap entries
  logic [LB-1:0]      lk;        // leaf being loaded or coded
  logic [SB-1:0]      ii;        // heapify position
  logic [KB-1:0]      kk;        // sift hole position
  logic [KB-1:0]      jj;        // sift child position
  logic [HEW-1:0]     hv;        // entry being sifted
  logic [HEW-1:0]     cj;        // smaller child entry
  logic [HEW-1:0]     t_ent;     // smallest entry removed in a merge
  logic [NB-1:0]      oth_node;  // second entry of a merge
  logic [CODE_W-1:0]  cw;        // code bits gathered on the walk
  logic [NB-1:0]      n;         // depth of the walk
  logic [TOTAL_W-1:0] total;
  logic [SYM_W-1:0]   sym_r;
  logic [ALPHABET-1:0] wvalid;   // leaf count written since clear
  logic [ALPHABET-1:0] cvalid;   // code table entry written since reset

  // Output register.
  logic               o_valid;
  logic [SYM_W-1:0]   o_sym;
  logic [CODE_W-1:0]  o_code;
  logic [LEN_W-1:0]   o_len;
  logic [TOTAL_W-1:0] o_total;
  logic               o_last;

  // Memory ports.
  logic                  wt_we;
  logic [LB-1:0]         wt_waddr, wt_raddr;
  logic [COUNT_BITS-1:0] wt_wdata, wt_rdata;
  logic                  hp_we;
  logic [HAW-1:0]        hp_waddr, hp_raddr;
  logic [HEW-1:0]        hp_wdata, hp_rdata;
  logic                  pl_we;
  logic [NB-1:0]         pl_waddr, pl_raddr;
  logic [PW-1:0]         pl_wdata, pl_rdata;
  logic                  ct_we;
  logic [CTW-1:0]        ct_wdata, ct_rdata;
  logic [LB-1:0]         ct_raddr;

  // Derived values.
  logic                  in_acc, ofree, leaf_used, sym_ok, o_load;
  logic [COUNT_BITS-1:0] cnt_cur;
  logic [NB-1:0]         merge_node, pl_parent;
  logic [WW-1:0]         merge_sum;
  logic [KB-1:0]         half_size;
  logic [LEN_W-1:0]      enc_len;
  logic [CODE_W-1:0]     enc_code;

  assign in_acc     = item.valid && item.ready;
  assign item.ready = (state == IDLE);
  assign ofree      = !o_valid || result.ready;
  // A new word enters the output register in the encode and table output states.
  assign o_load     = ((state == ENC) || (state == D_OUT)) && ofree;
  assign leaf_used  = wvalid[lk] && (wt_rdata != '0);
  assign cnt_cur    = wvalid[LB'(sym_r)] ? wt_rdata : '0;
  assign merge_node = NB'(ALPHABET - 1) + NB'(size);
  assign merge_sum  = hp_rdata[WW-1:0] + t_ent[WW-1:0];
  assign half_size  = KB'(size) >> 1;
  assign pl_parent  = pl_rdata[NB-1:0];
  assign sym_ok     = (32'(sym_r) < ALPHABET) && cvalid[LB'(sym_r)];
  assign enc_len    = sym_ok ? ct_rdata[CTW-1:CODE_W] : '0;
  assign enc_code   = sym_ok ? ct_rdata[CODE_W-1:0] : '0;

  // Memory control follows the sequencer state.
  always_comb begin
    wt_raddr = (state == IDLE) ? LB'(item.symbol) : lk;
    wt_we    = (state == CNT) && (cnt_cur != COUNT_MAX);
    wt_waddr = LB'(sym_r);
    wt_wdata = cnt_cur + 1'b1;

    // The encode lookup keeps its address while the answer waits to go out.
    ct_raddr = (state == IDLE) ? LB'(item.symbol) : LB'(sym_r);
    ct_we    = (state == D_OUT) && ofree;
    ct_wdata = {n[LEN_W-1:0], cw};

    hp_we    = 1'b0;
    hp_waddr = '0;
    hp_wdata = hv;
    hp_raddr = HAW'(1);

    pl_we    = 1'b0;
    pl_waddr = NB'(lk);
    pl_wdata = '0;
    pl_raddr = NB'(lk);

    case (state)
      L_WR: begin
        if (leaf_used) begin
          hp_we    = 1'b1;
          hp_waddr = HAW'(KB'(size) + 1'b1);
          hp_wdata = {NB'(lk), WW'(wt_rdata)};
          pl_we    = 1'b1;
        end
      end
      H_RD:  hp_raddr = HAW'(ii);
      S_CHK: hp_raddr = HAW'(kk << 1);
      S_RJ:  hp_raddr = HAW'(jj + 1'b1);
      S_CMP: begin
        if (hv[WW-1:0] > cj[WW-1:0]) begin
          hp_we    = 1'b1;
          hp_waddr = HAW'(kk);
          hp_wdata = cj;
        end
      end
      S_END: begin
        hp_we    = 1'b1;
        hp_waddr = HAW'(kk);
      end
      M_T:   hp_raddr = HAW'(size);
      M_L: begin
        hp_we    = 1'b1;
        hp_waddr = HAW'(1);
        hp_wdata = hp_rdata;
      end
      M_O2: begin
        hp_we    = 1'b1;
        hp_waddr = HAW'(1);
        hp_wdata = {merge_node, merge_sum};
        pl_we    = 1'b1;
        pl_waddr = t_ent[HEW-1:WW];
        pl_wdata = {1'b0, merge_node};
      end
      M_P2: begin
        pl_we    = 1'b1;
        pl_waddr = oth_node;
        pl_wdata = {1'b1, hv[HEW-1:WW]};
      end
      F_WR: begin
        pl_we    = 1'b1;
        pl_waddr = hp_rdata[HEW-1:WW];
      end
      D_P:   pl_raddr = pl_parent;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      ret     <= IDLE;
      size    <= '0;
      total   <= '0;
      wvalid  <= '0;
      cvalid  <= '0;
      o_valid <= 1'b0;
    end else begin
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_acc) begin
            sym_r <= item.symbol;
            case (item.command)
              CMD_CLEAR: begin
                wvalid <= '0;
                total  <= '0;
              end
              CMD_COUNT: begin
                if (32'(item.symbol) < ALPHABET) begin
                  state <= CNT;
                end
              end
              CMD_BUILD: begin
                size  <= '0;
                lk    <= '0;
                state <= L_RD;
              end
              CMD_ENCODE: state <= ENC;
              default: ;
            endcase
          end
        end
        CNT: begin
          if (wt_we) begin
            wvalid[LB'(sym_r)] <= 1'b1;
          end
          state <= IDLE;
        end
        ENC: begin
          if (ofree) begin
            o_sym   <= sym_r;
            o_code  <= enc_code;
            o_len   <= enc_len;
            o_total <= total + TOTAL_W'(enc_len);
            o_last  <= 1'b1;
            total   <= total + TOTAL_W'(enc_len);
            state   <= IDLE;
          end
        end
        // Every used leaf goes into the heap in index order.
        L_RD: state <= L_WR;
        L_WR: begin
          if (leaf_used) begin
            size <= size + 1'b1;
          end
          if (32'(lk) == ALPHABET - 1) begin
            state <= H_START;
          end else begin
            lk    <= lk + 1'b1;
            state <= L_RD;
          end
        end
        // Heapify from the last parent down to the root.
        H_START: begin
          ii    <= size >> 1;
          state <= ((size >> 1) == '0) ? M_TOP : H_RD;
        end
        H_RD: state <= H_GET;
        H_GET: begin
          hv    <= hp_rdata;
          kk    <= KB'(ii);
          ret   <= H_NEXT;
          state <= S_CHK;
        end
        H_NEXT: begin
          if (ii == SB'(1)) begin
            state <= M_TOP;
          end else begin
            ii    <= ii - 1'b1;
            state <= H_RD;
          end
        end
        // Sift down: the hole moves toward the smaller child.
        S_CHK: begin
          if (kk <= half_size) begin
            jj    <= kk << 1;
            state <= S_RJ;
          end else begin
            state <= S_END;
          end
        end
        S_RJ: begin
          cj    <= hp_rdata;
          state <= (jj < KB'(size)) ? S_RJ1 : S_CMP;
        end
        S_RJ1: begin
          if (cj[WW-1:0] > hp_rdata[WW-1:0]) begin
            cj <= hp_rdata;
            jj <= jj + 1'b1;
          end
          state <= S_CMP;
        end
        S_CMP: begin
          if (hv[WW-1:0] <= cj[WW-1:0]) begin
            state <= S_END;
          end else begin
            kk    <= jj;
            state <= S_CHK;
          end
        end
        S_END: state <= ret;
        // Merge the two smallest entries into a new internal node.
        M_TOP: state <= (size > SB'(1)) ? M_T : F_RD;
        M_T: begin
          t_ent <= hp_rdata;
          state <= M_L;
        end
        M_L: begin
          hv    <= hp_rdata;
          size  <= size - 1'b1;
          kk    <= KB'(1);
          ret   <= M_O;
          state <= S_CHK;
        end
        M_O: state <= M_O2;
        M_O2: begin
          oth_node <= hp_rdata[HEW-1:WW];
          hv       <= {merge_node, merge_sum};
          state    <= M_P2;
        end
        M_P2: begin
          kk    <= KB'(1);
          ret   <= M_TOP;
          state <= S_CHK;
        end
        // A lone remaining entry is the root.
        F_RD: begin
          lk    <= '0;
          state <= (size == SB'(1)) ? F_WR : D_RD;
        end
        F_WR: state <= D_RD;
        // Walk each used leaf up to the root to collect its code.
        D_RD: state <= D_W;
        D_W: begin
          cw    <= '0;
          n     <= '0;
          state <= leaf_used ? D_P : D_OUT;
        end
        D_P: begin
          if (pl_parent != '0) begin
            if (pl_rdata[NB] && (32'(n) < CODE_W)) begin
              cw <= cw | (CODE_W'(1) << n);
            end
            n <= n + 1'b1;
          end else begin
            state <= D_OUT;
          end
        end
        D_OUT: begin
          if (ofree) begin
            cvalid[lk] <= 1'b1;
            o_sym      <= SYM_W'(lk);
            o_code     <= cw;
            o_len      <= n[LEN_W-1:0];
            o_total    <= total;
            o_last     <= (32'(lk) == ALPHABET - 1);
            if (32'(lk) == ALPHABET - 1) begin
              state <= IDLE;
            end else begin
              lk    <= lk + 1'b1;
              state <= D_RD;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign result.valid       = o_valid;
  assign result.out_symbol  = o_sym;
  assign result.code_word   = o_code;
  assign result.code_length = o_len;
  assign result.bit_total   = o_total;
  assign result.last        = o_last;

  hcb_ram #(.WIDTH(COUNT_BITS), .DEPTH(ALPHABET)) u_weight (
    .clk(clk), .we(wt_we), .waddr(wt_waddr), .wdata(wt_wdata),
    .raddr(wt_raddr), .rdata(wt_rdata)
  );

  hcb_ram #(.WIDTH(HEW), .DEPTH(ALPHABET + 2)) u_heap (
    .clk(clk), .we(hp_we), .waddr(hp_waddr), .wdata(hp_wdata),
    .raddr(hp_raddr), .rdata(hp_rdata)
  );

  hcb_ram #(.WIDTH(PW), .DEPTH(2 * ALPHABET)) u_parent (
    .clk(clk), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
    .raddr(pl_raddr), .rdata(pl_rdata)
  );

  hcb_ram #(.WIDTH(CTW), .DEPTH(ALPHABET)) u_code (
    .clk(clk), .we(ct_we), .waddr(lk), .wdata(ct_wdata),
    .raddr(ct_raddr), .rdata(ct_rdata)
  );

  // The heap never holds more entries than the alphabet has symbols.
  a_heap_bound: assert property (@(posedge clk) disable iff (rst)
    32'(size) <= ALPHABET)
    else $error("heap size beyond alphabet");

  // A count command leaves the bit total alone.
  a_count_total: assert property (@(posedge clk) disable iff (rst)
    (in_acc && item.command == CMD_COUNT) |=> $stable(total))
    else $error("count changed bit total");

  // While a build still has entries to send, no new command is taken.
  a_build_busy: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.last) |-> !item.ready)
    else $error("command accepted during build output");

  // Every sift starts with a hole at a real heap position.
  a_sift_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK) |-> (kk != '0 && kk <= KB'(size)))
    else $error("sift position outside heap");

endmodule

`default_nettype wire
